/* src/bxavg_pkg.sv */
package bxavg_pkg;

    localparam int PIX_W   = 8;
    localparam int SF_W    = 5;
    localparam int WD_W    = 13;
    localparam int HT_W    = 13;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_SUB_FACTOR = 2'd0;
    localparam logic [1:0] REG_IN_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IN_HEIGHT  = 2'd2;

    typedef struct packed {
        logic take_px;
        logic acc;
        logic nblk_start;
        logic avg_start;
        logic nblk_load;
        logic emit_load;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic blk_done;
        logic div_done;
        logic out_free;
        logic emit_last;
    } t_sts;

endpackage

/* src/bxavg_ram.sv */
module bxavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bxavg_div.sv */
module bxavg_div #(
    parameter int Q_W   = 16,
    parameter int DVS_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [Q_W-1:0]   i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [Q_W-1:0]   o_quotient,
    output logic             o_done
);

    localparam int SH_W  = DVS_W + Q_W - 1;
    localparam int CNT_W = $clog2(Q_W);

    logic [Q_W-1:0]   r_rem;
    logic [SH_W-1:0]  r_dvs;
    logic [Q_W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             fits;
    logic [Q_W-1:0]   diff;

    // The divisor starts shifted up by Q_W-1 and walks down one bit per cycle.
    assign fits = SH_W'(r_rem) >= r_dvs;
    assign diff = r_rem - r_dvs[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dvs <= {i_divisor, {(Q_W-1){1'b0}}};
            r_quo <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= diff;
            end
            r_quo <= {r_quo[Q_W-2:0], fits};
            r_dvs <= r_dvs >> 1;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_start |-> !r_busy)
        else $error("divider restarted while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("divider reports done while still busy");

endmodule

/* src/bxavg_dp.sv */
module bxavg_dp #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bxavg_pkg::t_cmd                i_cmd,
    output bxavg_pkg::t_sts                o_sts,
    input  logic [bxavg_pkg::SF_W-1:0]     i_sub_factor,
    input  logic [bxavg_pkg::WD_W-1:0]     i_in_width,
    input  logic [bxavg_pkg::HT_W-1:0]     i_in_height,
    input  logic [bxavg_pkg::PIX_W-1:0]    i_pixel,
    input  logic                           i_stall,
    output logic [bxavg_pkg::PIX_W-1:0]    o_out_pixel,
    output logic                           o_is_padding,
    output logic                           o_row_last,
    output logic                           o_valid
);

    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HW    = bxavg_pkg::HT_W;
    localparam int CX_W  = WID_W + 1;
    localparam int RX_W  = HW + 1;
    localparam int SUM_W = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
    localparam int DVS_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int Q_W   = (SUM_W > WID_W) ? SUM_W : WID_W;
    localparam int PW    = bxavg_pkg::PIX_W;

    logic [FW-1:0]    s_eff;
    logic [WID_W-1:0] w_eff;
    logic [HW-1:0]    h_eff;
    logic [2*FW-1:0]  sq_full;

    logic [CW-1:0]    r_in_col, r_out_col, n_in_col, n_out_col;
    logic [HW-1:0]    r_in_row, n_in_row;
    logic [FW-1:0]    r_cib, r_rib, n_cib, n_rib;

    logic [PW-1:0]    r_px;
    logic             r_first, r_done, r_row_end;
    logic [CW-1:0]    r_addr;
    logic [1:0]       r_nres, r_emit_idx, pad;
    logic [DVS_W-1:0] r_sq;
    logic [WID_W-1:0] r_nblk;
    logic             row_end;

    logic [SUM_W-1:0] ram_rdata, n_sum;
    logic [Q_W-1:0]   div_dividend, quo;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;

    logic [CX_W-1:0]  col_x, cib_x;
    logic [RX_W-1:0]  row_x, rib_x;
    logic             col_ok, row_ok;

    logic             r_ovalid, r_opad, r_olast;
    logic [PW-1:0]    r_opix;

    // Out-of-range register values are clamped to what the hardware supports.
    always_comb begin
        if (i_sub_factor == '0) begin
            s_eff = FW'(1);
        end else if (32'(i_sub_factor) > 32'(MAX_FACTOR)) begin
            s_eff = FW'(MAX_FACTOR);
        end else begin
            s_eff = FW'(i_sub_factor);
        end
        if (i_in_width == '0) begin
            w_eff = WID_W'(1);
        end else if (32'(i_in_width) > 32'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(i_in_width);
        end
        h_eff = (i_in_height == '0) ? HW'(1) : i_in_height;
    end

    assign sq_full = {{FW{1'b0}}, s_eff} * {{FW{1'b0}}, s_eff};

    // A pixel counts only when it lies inside a whole block of the frame.
    assign col_x  = CX_W'(r_in_col);
    assign cib_x  = CX_W'(r_cib);
    assign row_x  = RX_W'(r_in_row);
    assign rib_x  = RX_W'(r_rib);
    assign col_ok = (r_cib < s_eff) && (col_x >= cib_x) &&
                    (col_x - cib_x + CX_W'(s_eff) <= CX_W'(w_eff));
    assign row_ok = (r_rib < s_eff) && (row_x >= rib_x) &&
                    (row_x - rib_x + RX_W'(s_eff) <= RX_W'(h_eff));

    always_comb begin
        logic [WID_W-1:0] nc;
        logic [FW-1:0]    ncib;
        logic [RX_W-1:0]  nr;
        logic [FW-1:0]    nrib;
        nc        = WID_W'(r_in_col) + WID_W'(1);
        ncib      = r_cib + FW'(1);
        nr        = row_x + RX_W'(1);
        nrib      = r_rib + FW'(1);
        n_in_col  = CW'(nc);
        n_cib     = ncib;
        n_out_col = r_out_col;
        n_in_row  = r_in_row;
        n_rib     = r_rib;
        if (ncib >= s_eff) begin
            n_cib     = '0;
            n_out_col = r_out_col + CW'(1);
        end
        if (nc >= w_eff) begin
            n_in_col  = '0;
            n_cib     = '0;
            n_out_col = '0;
            n_in_row  = HW'(nr);
            n_rib     = (nrib >= s_eff) ? '0 : nrib;
            if (nr >= RX_W'(h_eff)) begin
                n_in_row = '0;
                n_rib    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_out_col <= '0;
            r_in_row  <= '0;
            r_cib     <= '0;
            r_rib     <= '0;
        end else if (i_cmd.take_px) begin
            r_in_col  <= n_in_col;
            r_out_col <= n_out_col;
            r_in_row  <= n_in_row;
            r_cib     <= n_cib;
            r_rib     <= n_rib;
        end
    end

    // Padding fills the output row up to a multiple of four bytes.
    assign row_end = (WID_W'(r_out_col) + WID_W'(1)) == r_nblk;
    assign pad     = 2'd0 - r_nblk[1:0];

    always_ff @(posedge i_clk) begin
        r_sq <= DVS_W'(sq_full);
        if (i_cmd.take_px) begin
            r_px      <= i_pixel;
            r_first   <= (r_cib == '0) && (r_rib == '0);
            r_done    <= (r_cib == s_eff - FW'(1)) && (r_rib == s_eff - FW'(1));
            r_addr    <= r_out_col;
            r_row_end <= row_end;
            r_nres    <= row_end ? pad : 2'd0;
        end
        if (i_cmd.nblk_load) begin
            r_nblk <= quo[WID_W-1:0];
        end
    end

    assign n_sum = r_first ? SUM_W'(r_px) : ram_rdata + SUM_W'(r_px);

    bxavg_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acc),
        .i_waddr (r_addr),
        .i_wdata (n_sum),
        .i_raddr (r_out_col),
        .o_rdata (ram_rdata)
    );

    // The divider is shared between blocks per row and the block mean.
    assign div_dividend = i_cmd.nblk_start ? Q_W'(w_eff) : Q_W'(n_sum);
    assign div_divisor  = i_cmd.nblk_start ? DVS_W'(s_eff) : r_sq;

    bxavg_div #(
        .Q_W   (Q_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.nblk_start | i_cmd.avg_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_idx <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.take_px) begin
                r_emit_idx <= '0;
            end else if (i_cmd.emit_load) begin
                r_emit_idx <= r_emit_idx + 2'd1;
            end
            if (i_cmd.emit_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_opix  <= (r_emit_idx == 2'd0) ? quo[PW-1:0] : '0;
            r_opad  <= r_emit_idx != 2'd0;
            r_olast <= r_row_end && (r_emit_idx == r_nres);
        end
    end

    assign o_sts.hit       = col_ok && row_ok;
    assign o_sts.blk_done  = r_done;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_ovalid || !i_stall;
    assign o_sts.emit_last = r_emit_idx == r_nres;

    assign o_out_pixel  = r_opix;
    assign o_is_padding = r_opad;
    assign o_row_last   = r_olast;
    assign o_valid      = r_ovalid;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc |-> $past(i_cmd.take_px))
        else $error("sum written without a pixel taken the cycle before");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |-> (!r_ovalid || !i_stall))
        else $error("output register overwritten while a transfer is pending");

endmodule

/* src/bxavg_ctrl.sv */
module bxavg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_cfg_wr,
    input  bxavg_pkg::t_sts i_sts,
    output bxavg_pkg::t_cmd o_cmd,
    output logic            o_stall
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_NBLK = 5'b00010,
        S_RD   = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_stale, n_stale;

    always_comb begin
        n_state = r_state;
        n_stale = r_stale;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                // Blocks per row are recomputed after every register write.
                if (r_stale) begin
                    o_cmd.nblk_start = 1'b1;
                    n_stale          = 1'b0;
                    n_state          = S_NBLK;
                end else begin
                    o_stall = 1'b0;
                    if (i_valid) begin
                        o_cmd.take_px = 1'b1;
                        if (i_sts.hit) begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_NBLK: begin
                if (i_sts.div_done) begin
                    o_cmd.nblk_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.acc = 1'b1;
                if (i_sts.blk_done) begin
                    o_cmd.avg_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_wr) begin
            n_stale = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stale <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stale <= n_stale;
        end
    end

endmodule

/* src/box_average_downsampler.sv */
// Channel    Direction  Signals                                      Handshake
// pixel in   input      i_pixel                                      i_valid / o_stall
// result     output     o_out_pixel, o_is_padding, o_row_last        o_valid / i_stall
// config     APB        psel, penable, pwrite, paddr, pwdata, prdata pready (always high)
//
// A pixel outside every whole block is taken in S_IDLE alone, a pixel inside a block
// also passes S_RD (the column sum is read, then written back). The pixel that completes a
// block also waits for the bit-serial divider, one quotient bit per cycle over 16 bits,
// and then for one emit per result byte.
// After reset and after every register write the same divider works out the blocks
// per row, and input is stalled while it does so.
// The result register lets a finished byte wait under i_stall while new pixels are taken.
module box_average_downsampler #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_FACTOR = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bxavg_pkg::PIX_W-1:0]        i_pixel,
    input  logic                               i_valid,
    output logic                               o_stall,
    output logic [bxavg_pkg::PIX_W-1:0]        o_out_pixel,
    output logic                               o_is_padding,
    output logic                               o_row_last,
    output logic                               o_valid,
    input  logic                               i_stall,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bxavg_pkg::PADDR_W-1:0]      paddr,
    input  logic [bxavg_pkg::PDATA_W-1:0]      pwdata,
    output logic [bxavg_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);

    logic [bxavg_pkg::SF_W-1:0] r_sub_factor;
    logic [bxavg_pkg::WD_W-1:0] r_in_width;
    logic [bxavg_pkg::HT_W-1:0] r_in_height;
    logic [1:0]                 reg_idx;
    logic                       cfg_wr;
    bxavg_pkg::t_cmd            cmd;
    bxavg_pkg::t_sts            sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bxavg_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_factor <= bxavg_pkg::SF_W'(1);
            r_in_width   <= bxavg_pkg::WD_W'(4096);
            r_in_height  <= bxavg_pkg::HT_W'(4096);
        end else if (cfg_wr) begin
            case (reg_idx)
                bxavg_pkg::REG_SUB_FACTOR: r_sub_factor <= pwdata[bxavg_pkg::SF_W-1:0];
                bxavg_pkg::REG_IN_WIDTH:   r_in_width   <= pwdata[bxavg_pkg::WD_W-1:0];
                bxavg_pkg::REG_IN_HEIGHT:  r_in_height  <= pwdata[bxavg_pkg::HT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bxavg_pkg::REG_SUB_FACTOR: prdata = bxavg_pkg::PDATA_W'(r_sub_factor);
            bxavg_pkg::REG_IN_WIDTH:   prdata = bxavg_pkg::PDATA_W'(r_in_width);
            bxavg_pkg::REG_IN_HEIGHT:  prdata = bxavg_pkg::PDATA_W'(r_in_height);
            default:                   prdata = '0;
        endcase
    end

    bxavg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cfg_wr (cfg_wr),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    bxavg_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_sub_factor (r_sub_factor),
        .i_in_width   (r_in_width),
        .i_in_height  (r_in_height),
        .i_pixel      (i_pixel),
        .i_stall      (i_stall),
        .o_out_pixel  (o_out_pixel),
        .o_is_padding (o_is_padding),
        .o_row_last   (o_row_last),
        .o_valid      (o_valid)
    );

endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W       = 4096;
    localparam int MAX_F       = 16;
    localparam int IDLE_WAIT   = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_PIXELS = 350;
    localparam int MAX_PRINTS  = 50;

    typedef struct packed {
        logic [bxavg_pkg::PIX_W-1:0] value;
        logic                        pad;
        logic                        last;
    } t_out_byte;

    // Mirrors the decimator: register copies, block sums and raster position,
    // plus the queue of output bytes still owed by the block.
    class box_mean_scoreboard;
        logic [bxavg_pkg::SF_W-1:0] factor_reg;
        logic [bxavg_pkg::WD_W-1:0] width_reg;
        logic [bxavg_pkg::HT_W-1:0] height_reg;
        int unsigned     block_sum [MAX_W];
        int unsigned     col, row, blk_col, blk_row, out_col;
        t_out_byte       expected_q [$];
        int              errors;

        function new();
            factor_reg = bxavg_pkg::SF_W'(1);
            width_reg  = bxavg_pkg::WD_W'(4096);
            height_reg = bxavg_pkg::HT_W'(4096);
            col        = 0;
            row        = 0;
            blk_col    = 0;
            blk_row    = 0;
            out_col    = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [bxavg_pkg::PDATA_W-1:0] data);
            case (idx)
                bxavg_pkg::REG_SUB_FACTOR: factor_reg = data[bxavg_pkg::SF_W-1:0];
                bxavg_pkg::REG_IN_WIDTH:   width_reg  = data[bxavg_pkg::WD_W-1:0];
                bxavg_pkg::REG_IN_HEIGHT:  height_reg = data[bxavg_pkg::HT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [bxavg_pkg::PIX_W-1:0] px);
            int unsigned s, w, h, nblk, pad, avg, k;
            bit          col_ok, row_ok, row_end;
            t_out_byte   e;
            s = (factor_reg == 0) ? 1 : (factor_reg > MAX_F) ? MAX_F : 32'(factor_reg);
            w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : 32'(width_reg);
            h = (height_reg == 0) ? 1 : 32'(height_reg);
            nblk = w / s;
            col_ok = blk_col < s && col >= blk_col && col - blk_col + s <= w &&
                     out_col < MAX_W;
            row_ok = blk_row < s && row >= blk_row && row - blk_row + s <= h;
            if (col_ok && row_ok) begin
                if (blk_col == 0 && blk_row == 0)
                    block_sum[out_col] = 32'(px);
                else
                    block_sum[out_col] += 32'(px);
                if (blk_col == s - 1 && blk_row == s - 1) begin
                    avg = block_sum[out_col] / (s * s);
                    row_end = (out_col + 1 == nblk);
                    pad = row_end ? (4 - nblk % 4) % 4 : 0;
                    e.value = avg[bxavg_pkg::PIX_W-1:0];
                    e.pad   = 1'b0;
                    e.last  = row_end && pad == 0;
                    expected_q.push_back(e);
                    for (k = 0; k < pad; k++) begin
                        e.value = '0;
                        e.pad   = 1'b1;
                        e.last  = (k + 1 == pad);
                        expected_q.push_back(e);
                    end
                end
            end
            col++;
            blk_col++;
            if (blk_col >= s) begin
                blk_col = 0;
                out_col++;
            end
            if (col >= w) begin
                col = 0;
                blk_col = 0;
                out_col = 0;
                row++;
                blk_row++;
                if (blk_row >= s) blk_row = 0;
                if (row >= h) begin
                    row = 0;
                    blk_row = 0;
                end
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_result(t_out_byte seen);
            t_out_byte want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected byte value=%0d pad=%0b last=%0b",
                                 seen.value, seen.pad, seen.last));
                return;
            end
            want = expected_q.pop_front();
            if (seen.value !== want.value || seen.pad !== want.pad ||
                seen.last !== want.last) begin
                report($sformatf("byte value=%0d pad=%0b last=%0b, wanted %0d/%0b/%0b",
                                 seen.value, seen.pad, seen.last,
                                 want.value, want.pad, want.last));
            end
        endtask
    endclass

    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic [bxavg_pkg::PIX_W-1:0]       i_pixel      = '0;
    logic                              i_valid      = 1'b0;
    logic                              o_stall;
    logic [bxavg_pkg::PIX_W-1:0]       o_out_pixel;
    logic                              o_is_padding;
    logic                              o_row_last;
    logic                              o_valid;
    logic                              i_stall      = 1'b0;
    logic                              psel         = 1'b0;
    logic                              penable      = 1'b0;
    logic                              pwrite       = 1'b0;
    logic [bxavg_pkg::PADDR_W-1:0]     paddr        = '0;
    logic [bxavg_pkg::PDATA_W-1:0]     pwdata       = '0;
    logic [bxavg_pkg::PDATA_W-1:0]     prdata;
    logic                              pready;

    box_mean_scoreboard sb;
    t_out_byte          seen_byte;
    int                 quiet_cycles = 0;
    int                 stall_left   = 0;
    bit                 calm         = 1'b0;
    int                 px_style     = 0;

    logic [bxavg_pkg::PIX_W-1:0] first_frame [8] = '{8'd0, 8'd0, 8'd255, 8'd255,
                                                     8'd1, 8'd2, 8'd255, 8'd255};

    box_average_downsampler #(
        .MAX_WIDTH (MAX_W),
        .MAX_FACTOR(MAX_F)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pixel     (i_pixel),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_out_pixel (o_out_pixel),
        .o_is_padding(o_is_padding),
        .o_row_last  (o_row_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    function int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function int pick_gap();
        if (calm || $urandom_range(0, 99) >= 30) return 0;
        return idle_len();
    endfunction

    function logic [bxavg_pkg::PIX_W-1:0] pick_px();
        case (px_style)
            2: return bxavg_pkg::PIX_W'($urandom_range(224, 255));
            3: return bxavg_pkg::PIX_W'($urandom_range(0, 31));
            default: return bxavg_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left = idle_len() - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Results are checked before the pixel of the same edge is noted, so a stray
    // output byte can never consume an expectation that was just created.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                seen_byte.value = o_out_pixel;
                seen_byte.pad   = o_is_padding;
                seen_byte.last  = o_row_last;
                sb.check_result(seen_byte);
            end
            if (i_valid && !o_stall) sb.note_pixel(i_pixel);
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task send_pixel(logic [bxavg_pkg::PIX_W-1:0] px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task feed(int n);
        repeat (n) send_pixel(pick_px());
    endtask

    task apb_write(logic [1:0] idx, int unsigned data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Ignored pixels give no result, so the block may still be busy after the
    // last expected transfer; the extra wait covers a full block completion.
    task wait_idle();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    task configure(int unsigned sf, int unsigned wd, int unsigned ht);
        wait_idle();
        apb_write(bxavg_pkg::REG_SUB_FACTOR, sf);
        apb_write(bxavg_pkg::REG_IN_WIDTH, wd);
        apb_write(bxavg_pkg::REG_IN_HEIGHT, ht);
    endtask

    // With a factor of one every block sum is written before it is read, and a
    // one by one frame returns all counters to zero after a single pixel.
    task resync();
        configure(1, 1, 1);
        send_pixel(pick_px());
    endtask

    initial begin
        int unsigned s, w, h, sf, wd, ht, nfr, total, done_px, r, n;
        sb = new();
        done_px = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Two blocks of a 4x2 frame: one floors to zero, one is all 255.
        configure(2, 4, 2);
        foreach (first_frame[k]) send_pixel(first_frame[k]);

        // Tall frame: height taken as given, no wrap after the first band.
        configure(2, 4, 8191);
        feed(8);

        // Oversized factor clamps to 16; the frame is narrower than that, so
        // nothing comes out. Changed in the middle of the frame on purpose.
        configure(31, 8, 8191);
        feed(3);
        resync();

        // Zero factor, width and height all act as one: four bytes per pixel.
        configure(0, 0, 0);
        send_pixel(8'd255);
        send_pixel(8'd0);

        // Width and height changed in the middle of a frame, counters kept.
        px_style = 0;
        configure(2, 8, 8);
        feed(19);
        configure(2, 6, 5);
        feed(15);

        // The pixel budget cuts the last frame short and realigns the counters.
        while (done_px < RAND_PIXELS) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                s = $urandom_range(1, 4);
            else if (r < 85)
                s = $urandom_range(5, 8);
            else
                s = $urandom_range(9, 16);
            if ($urandom_range(0, 9) == 0) begin
                w = (s > 1) ? $urandom_range(1, s - 1) : 1;
                h = $urandom_range(1, 3);
            end else if (s <= 4) begin
                w = $urandom_range(s, 24);
                h = $urandom_range(s, 3 * s + 2);
            end else if (s <= 8) begin
                w = $urandom_range(s, 2 * s + 3);
                h = $urandom_range(s, 2 * s);
            end else begin
                w = $urandom_range(s, s + 3);
                h = $urandom_range(s, s + 2);
            end
            sf = s;
            if (s == 1 && $urandom_range(0, 1) == 1) sf = 0;
            if (s == 16 && $urandom_range(0, 1) == 1) sf = $urandom_range(17, 31);
            wd = (w == 1 && $urandom_range(0, 1) == 1) ? 0 : w;
            ht = (h == 1 && $urandom_range(0, 1) == 1) ? 0 : h;
            calm     = ($urandom_range(0, 4) == 0);
            px_style = $urandom_range(0, 3);
            nfr      = $urandom_range(1, 2);
            total    = w * h * nfr;
            configure(sf, wd, ht);
            if (done_px + total > RAND_PIXELS) begin
                n = RAND_PIXELS - done_px;
                feed(n);
                resync();
                done_px += n + 1;
            end else if (total > 1 && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, total - 1);
                feed(n);
                resync();
                done_px += n + 1;
            end else begin
                feed(total);
                done_px += total;
            end
        end

        // An oversized width clamps to 4096 columns; a short run at the start
        // of such a row.
        calm     = 1'b0;
        px_style = 0;
        configure(0, 8191, 1);
        feed(24);

        wait_idle();
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
